>>> rtl/core/sct_pkg.sv
// Shared types, constants and coefficient tables of the sine/cosine series unit.
`default_nettype none

package sct_pkg;

  // Number format and series length.
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned TERMS     = 5;
  localparam int unsigned LAST_P    = 2 * TERMS;

  // Port field widths.
  localparam int unsigned ANGLE_W = 24;
  localparam int unsigned VALUE_W = 18;

  // pi and 2*pi in the fixed-point format (rounded from a 32 fraction bit value).
  localparam int unsigned PI_FX     = 205887;
  localparam int unsigned TWO_PI_FX = 411775;

  // Range reduction works on x + pi + RED_WRAPS*2*pi, which is positive for every
  // input angle, and strips multiples of 2*pi by restoring steps.
  localparam int unsigned RED_WRAPS  = 20;
  localparam int unsigned RED_OFFSET = PI_FX + RED_WRAPS * TWO_PI_FX;
  localparam int unsigned RED_W      = 25;
  localparam int unsigned RED_STEPS  = 6;
  localparam int unsigned RED_CNT_W  = $clog2(RED_STEPS);

  // Datapath widths.
  localparam int unsigned AX_W   = 18;  // |x| after reduction, at most pi
  localparam int unsigned X2_W   = 20;  // x^2, at most pi^2
  localparam int unsigned MAG_W  = 20;  // magnitude of one series term
  localparam int unsigned Q_W    = 23;  // rounded product before the divide
  localparam int unsigned SUM_W  = 24;  // running series sum
  localparam int unsigned P_W    = 4;   // current power of x
  localparam int unsigned TDIV_W = 7;   // p*(p-1)

  // Constant division by p*(p-1) uses ceil(2^RCP_SHIFT / (p*(p-1))), which is exact
  // for every dividend below 2^Q_W because p*(p-1) stays below 2^TDIV_W.
  localparam int unsigned RCP_SHIFT = Q_W + TDIV_W;
  localparam int unsigned RCP_W     = RCP_SHIFT;

  // Shared multiplier.
  localparam int unsigned MUL_A_W = Q_W;
  localparam int unsigned MUL_B_W = RCP_W;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_PREP,
    ST_SQUARE,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } sct_state_e;

  typedef struct packed {
    logic                 load;
    logic                 reduce;
    logic                 prep;
    logic                 square;
    logic                 mul;
    logic                 div;
    logic                 store;
    logic [RED_CNT_W-1:0] red_shift;
    logic [P_W-1:0]       p;
  } sct_cmd_t;

  typedef struct packed {
    logic cosine;
  } sct_sts_t;

  function automatic logic [TDIV_W-1:0] term_div(input logic [P_W-1:0] p);
    logic [P_W-1:0] pm1;
    pm1 = p - P_W'(1);
    return TDIV_W'(p * pm1);
  endfunction

  function automatic logic [RCP_W-1:0] term_recip(input logic [P_W-1:0] p);
    logic [RCP_W-1:0] r;
    case (p)
      4'd2:    r = RCP_W'(536870912);
      4'd3:    r = RCP_W'(178956971);
      4'd4:    r = RCP_W'(89478486);
      4'd5:    r = RCP_W'(53687092);
      4'd6:    r = RCP_W'(35791395);
      4'd7:    r = RCP_W'(25565282);
      4'd8:    r = RCP_W'(19173962);
      4'd9:    r = RCP_W'(14913081);
      4'd10:   r = RCP_W'(11930465);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/sct_if.sv
// Valid/ready channel interfaces for the angle input and the series result output.
`default_nettype none

interface sct_in_if import sct_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic signed [ANGLE_W-1:0] angle;

  modport source (output valid, output action, output angle, input ready);
  modport sink (input valid, input action, input angle, output ready);
endinterface

interface sct_out_if import sct_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sct_ctrl.sv
// Sequencer of the sine/cosine unit: steps the datapath through reduction and series terms.
`default_nettype none

module sct_ctrl
  import sct_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  input  sct_sts_t sts_i,
  output sct_cmd_t cmd_o
);

  sct_state_e           state_q, state_d;
  logic [RED_CNT_W-1:0] cnt_q, cnt_d;
  logic [P_W-1:0]       p_q, p_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;

  assign out_free = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    p_d     = p_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_REDUCE;
          cnt_d   = RED_CNT_W'(RED_STEPS - 1);
        end
      end
      ST_REDUCE: begin
        cnt_d = cnt_q - RED_CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        state_d = ST_SQUARE;
      end
      ST_SQUARE: begin
        p_d     = sts_i.cosine ? P_W'(2) : P_W'(3);
        state_d = ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (p_q > P_W'(LAST_P - 2)) begin
          state_d = ST_FIN;
        end else begin
          p_d     = p_q + P_W'(2);
          state_d = ST_MUL;
        end
      end
      ST_FIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.red_shift = cnt_q;
    cmd_o.p         = p_q;
    in_ready_o      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_REDUCE: cmd_o.reduce = 1'b1;
      ST_PREP:   cmd_o.prep = 1'b1;
      ST_SQUARE: cmd_o.square = 1'b1;
      ST_MUL:    cmd_o.mul = 1'b1;
      ST_DIV:    cmd_o.div = 1'b1;
      ST_DONE:   cmd_o.store = out_free;
      default: begin
        cmd_o.load = 1'b0;
      end
    endcase
  end

  // The output register stays full until the receiver takes the transaction.
  assign out_valid_d = (out_valid_q & ~out_ready_i) | cmd_o.store;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      p_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      p_q         <= p_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sct_dpath.sv
// Datapath of the sine/cosine unit: angle reduction, shared multiplier and series sum.
`default_nettype none

module sct_dpath
  import sct_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sct_cmd_t                  cmd_i,
  input  logic                      action_i,
  input  logic signed [ANGLE_W-1:0] angle_i,
  output sct_sts_t                  sts_o,
  output logic signed [VALUE_W-1:0] value_o
);

  localparam logic signed [SUM_W-1:0] SumMax = SUM_W'((1 << (VALUE_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SumMin = -SUM_W'(1 << (VALUE_W - 1));

  logic                      cos_q, cos_d;
  logic [RED_W-1:0]          y_q, y_d;
  logic [AX_W-1:0]           ax_q, ax_d;
  logic                      xneg_q, xneg_d;
  logic [X2_W-1:0]           x2_q, x2_d;
  logic [MAG_W-1:0]          mag_q, mag_d;
  logic                      neg_q, neg_d;
  logic [Q_W-1:0]            q_q, q_d;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic                      sub_q, sub_d;
  logic                      pend_q;
  logic signed [VALUE_W-1:0] value_q, value_d;

  logic [RED_W-1:0]        step_sub;
  logic [MUL_A_W-1:0]      mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  logic [PROD_W-1:0]       prod;
  logic [PROD_W-1:0]       round_add;
  logic [PROD_W-1:0]       rounded;
  logic signed [SUM_W-1:0] term_val;
  logic signed [SUM_W-1:0] x_signed;

  assign step_sub = RED_W'(TWO_PI_FX) << cmd_i.red_shift;

  // One multiplier serves the square, each term product and the constant divide.
  always_comb begin
    if (cmd_i.square) begin
      mul_a = MUL_A_W'(ax_q);
      mul_b = MUL_B_W'(ax_q);
    end else if (cmd_i.mul) begin
      mul_a = MUL_A_W'(mag_q);
      mul_b = MUL_B_W'(x2_q);
    end else begin
      mul_a = q_q;
      mul_b = term_recip(cmd_i.p);
    end
  end

  assign prod      = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign round_add = cmd_i.square ? (PROD_W'(1) << (FRAC_BITS - 1))
                                  : (PROD_W'(term_div(cmd_i.p)) << (FRAC_BITS - 1));
  assign rounded   = prod + round_add;

  assign term_val = neg_q ? -SUM_W'(mag_q) : SUM_W'(mag_q);
  assign x_signed = xneg_q ? -SUM_W'(ax_q) : SUM_W'(ax_q);

  always_comb begin
    cos_d  = cos_q;
    y_d    = y_q;
    ax_d   = ax_q;
    xneg_d = xneg_q;
    x2_d   = x2_q;
    mag_d  = mag_q;
    neg_d  = neg_q;
    q_d    = q_q;
    sum_d  = sum_q;
    sub_d  = sub_q;

    if (cmd_i.load) begin
      cos_d = action_i;
      y_d   = RED_W'(angle_i) + RED_W'(RED_OFFSET);
    end
    if (cmd_i.reduce && (y_q >= step_sub)) begin
      y_d = y_q - step_sub;
    end
    if (cmd_i.prep) begin
      xneg_d = y_q < RED_W'(PI_FX);
      ax_d   = (y_q < RED_W'(PI_FX)) ? AX_W'(RED_W'(PI_FX) - y_q)
                                     : AX_W'(y_q - RED_W'(PI_FX));
    end
    // A term finished by the divide step is added or subtracted in the next cycle, flagged by pend_q.
    if (pend_q) begin
      sum_d = sub_q ? (sum_q - term_val) : (sum_q + term_val);
      sub_d = ~sub_q;
    end
    if (cmd_i.square) begin
      x2_d  = rounded[FRAC_BITS +: X2_W];
      mag_d = cos_q ? MAG_W'(1 << FRAC_BITS) : MAG_W'(ax_q);
      neg_d = cos_q ? 1'b0 : xneg_q;
      sum_d = cos_q ? SUM_W'(1 << FRAC_BITS) : x_signed;
      sub_d = 1'b1;
    end
    if (cmd_i.mul) begin
      q_d = rounded[FRAC_BITS +: Q_W];
    end
    // Term magnitudes stay below pi^3/3! in the fixed-point format, so MAG_W bits hold them.
    if (cmd_i.div) begin
      mag_d = prod[RCP_SHIFT +: MAG_W];
    end
  end

  always_comb begin
    if (sum_q > SumMax) begin
      value_d = VALUE_W'(SumMax);
    end else if (sum_q < SumMin) begin
      value_d = VALUE_W'(SumMin);
    end else begin
      value_d = VALUE_W'(sum_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= cmd_i.div;
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q  <= cos_d;
    y_q    <= y_d;
    ax_q   <= ax_d;
    xneg_q <= xneg_d;
    x2_q   <= x2_d;
    mag_q  <= mag_d;
    neg_q  <= neg_d;
    q_q    <= q_d;
    sum_q  <= sum_d;
    sub_q  <= sub_d;
    if (cmd_i.store) begin
      value_q <= value_d;
    end
  end

  assign sts_o.cosine = cos_q;
  assign value_o      = value_q;

endmodule

`default_nettype wire

>>> rtl/core/sine_cosine_taylor_unit.sv
// Top level of the fixed-point sine/cosine unit built on a truncated Taylor series.
//
// Usage: an item on in_i carries action (0 sine, 1 cosine) and angle, radians in
// signed fixed point with 16 fraction bits. The result appears on out_o as value,
// signed fixed point with 16 fraction bits, one result transaction per input.
// The angle is first folded into [-pi, pi] by six restoring steps that strip
// multiples of 2*pi, then the series is evaluated on one shared multiplier:
// a square step for x^2 and, per term, a product step and then a constant divide.
// One item is worked on at a time: in_i.ready is high only while the sequencer
// is idle, so a new item is taken only once the previous one has been worked
// through the six reduction steps and its terms on the single shared multiplier.
// The result sits in an output register; the next item is accepted while it
// waits, and a stalled receiver holds that item in its final step until the
// register is taken. Reset returns the sequencer to idle and empties the
// output register; the datapath registers other than pend_q are not reset.
`default_nettype none

module sine_cosine_taylor_unit
  import sct_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  sct_in_if.sink           in_i,
  sct_out_if.source        out_o
);

  sct_cmd_t cmd;
  sct_sts_t sts;

  sct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sct_dpath u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .action_i (in_i.action),
    .angle_i  (in_i.angle),
    .sts_o    (sts),
    .value_o  (out_o.value)
  );

endmodule

`default_nettype wire

>>> test/sct_value_checker.sv
// Watches both channels of the sine/cosine unit, predicts each result and compares it.
module sct_value_checker
  import sct_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  sct_in_if           in_ch,
  sct_out_if          out_ch,
  output int unsigned err_cnt_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint HALF_LSB_Q32 = longint'(1) << (31 - FRAC_BITS);
  localparam longint PI_FIX     = (longint'(64'd13493037705) + HALF_LSB_Q32)
                                  >>> (32 - FRAC_BITS);
  localparam longint TWO_PI_FIX = (longint'(64'd26986075409) + HALF_LSB_Q32)
                                  >>> (32 - FRAC_BITS);
  localparam longint VALUE_MAX  = (longint'(1) << (VALUE_W - 1)) - 1;
  localparam longint VALUE_MIN  = -(longint'(1) << (VALUE_W - 1));

  logic signed [VALUE_W-1:0] value_q[$];

  // Folds the angle into [-pi, pi]; exact +-pi stays where it is.
  function automatic longint fold_angle(input longint x);
    longint n;
    n = 0;
    if (x > PI_FIX) begin
      n = (x - PI_FIX + TWO_PI_FIX - 1) / TWO_PI_FIX;
      x = x - n * TWO_PI_FIX;
    end else if (x < -PI_FIX) begin
      n = (-PI_FIX - x + TWO_PI_FIX - 1) / TWO_PI_FIX;
      x = x + n * TWO_PI_FIX;
    end
    return x;
  endfunction

  function automatic logic signed [VALUE_W-1:0] taylor_value(
    input logic                      cosine,
    input logic signed [ANGLE_W-1:0] angle
  );
    longint            x;
    longint            term;
    longint            sum;
    longint unsigned   ax;
    longint unsigned   x2;
    longint unsigned   mag;
    longint unsigned   den;
    bit                add;
    bit                neg;
    int unsigned       p;
    x    = fold_angle(longint'(angle));
    ax   = (x < 0) ? longint'(-x) : longint'(x);
    x2   = (ax * ax + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    term = cosine ? (longint'(1) << FRAC_BITS) : x;
    sum  = term;
    add  = 1'b0;
    for (p = cosine ? 2 : 3; p < 2 * TERMS + 1; p += 2) begin
      neg  = term < 0;
      mag  = neg ? longint'(-term) : longint'(term);
      den  = longint'(p * (p - 1)) << FRAC_BITS;
      mag  = (mag * x2 + den / 2) / den;
      term = neg ? -longint'(mag) : longint'(mag);
      sum  = add ? sum + term : sum - term;
      add  = !add;
    end
    if (sum > VALUE_MAX) sum = VALUE_MAX;
    if (sum < VALUE_MIN) sum = VALUE_MIN;
    return VALUE_W'(sum);
  endfunction

  always @(posedge clk_i) begin
    logic signed [VALUE_W-1:0] exp_value;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        value_q.push_back(taylor_value(in_ch.action, in_ch.angle));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (value_q.size() == 0) begin
          $display("%0t: result transaction with nothing expected, actual %0d", $time,
                   out_ch.value);
          err_cnt_o = err_cnt_o + 1;
        end else begin
          exp_value = value_q.pop_front();
          if (out_ch.value !== exp_value) begin
            $display("%0t: value mismatch, expected %0d, actual %0d", $time, exp_value,
                     out_ch.value);
            err_cnt_o = err_cnt_o + 1;
          end
        end
      end
      pending_o = value_q.size();
    end
  end

endmodule

>>> test/tb_top.sv
// Top of the sine/cosine unit testbench: clock, reset, stimulus and the verdict.
module tb_top;
  import sct_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1100;
  localparam int QUIET_ITEMS  = 150;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PI_I         = int'(PI_FX);
  localparam int TWO_PI_I     = int'(TWO_PI_FX);

  logic        clk_i;
  logic        rst_ni;
  bit          quiet;
  int unsigned err_cnt;
  int unsigned pending;
  int unsigned cycles;

  sct_in_if  in_ch ();
  sct_out_if out_ch ();

  sine_cosine_taylor_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  sct_value_checker value_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .err_cnt_o (err_cnt),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // One input transaction, with an optional idle burst in front of it.
  task automatic send_angle(input logic action, input int angle);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= action;
    in_ch.angle  <= ANGLE_W'(angle);
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  function automatic int random_angle();
    int a;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: a = int'($urandom_range(0, 2 * PI_I)) - PI_I;
      5, 6:          a = int'($signed(24'($urandom())));
      // Close to an odd multiple of pi, where the fold decides between +pi and -pi.
      7:             a = ($urandom_range(0, 1) ? PI_I : -PI_I)
                         + (int'($urandom_range(0, 38)) - 19) * TWO_PI_I
                         + int'($urandom_range(0, 6)) - 3;
      8:             a = int'($urandom_range(0, 511)) - 256;
      default:       a = (int'($urandom_range(0, 38)) - 19) * TWO_PI_I
                         + int'($urandom_range(0, 64)) - 32;
    endcase
    if (a > 8388607) a = 8388607;
    if (a < -8388608) a = -8388608;
    return a;
  endfunction

  // The receiver stalls in bursts until the quiet part of the run.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!quiet && rst_ni && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    int directed[12];
    quiet        = 1'b0;
    rst_ni       = 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.action <= 1'b0;
    in_ch.angle  <= '0;
    directed = '{0, 1, -1, PI_I, -PI_I, PI_I + 1, -PI_I - 1, PI_I / 2, -PI_I / 2,
                 TWO_PI_I, 8388607, -8388608};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_angle(1'b0, directed[i]);
      send_angle(1'b1, directed[i]);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      send_angle(1'($urandom_range(0, 1)), random_angle());
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
